[rtl/rrq_pkg.sv]
// rrq_pkg: shared constants, codes and word types of the round-robin run queue
// used by rrq_core and round_robin_run_queue_unit; no dependencies
package rrq_pkg;

    localparam int NUM_TASKS = 64;
    localparam int ID_W      = $clog2(NUM_TASKS);
    localparam int CNT_W     = $clog2(NUM_TASKS + 1);
    localparam int SLICE_W   = 8;

    localparam logic [SLICE_W-1:0] MAX_SLICE_RST = SLICE_W'(5);

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_PICK = 2'd2,
        OP_TICK = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ALREADY    = 2'd1,
        ST_NOT_QUEUED = 2'd2,
        ST_EMPTY      = 2'd3
    } status_t;

    typedef struct packed {
        opcode_t           opcode;
        logic [ID_W-1:0]   task_id;
    } in_word_t;

    typedef struct packed {
        status_t            status;
        logic [ID_W-1:0]    head_id;
        logic               resched_req;
        logic [CNT_W-1:0]   queue_count;
        logic [SLICE_W-1:0] slice_left;
    } out_word_t;

    typedef struct packed {
        logic            we;
        logic [ID_W-1:0] addr;
        logic [ID_W-1:0] data;
    } link_wr_t;

    typedef struct packed {
        logic               we;
        logic [ID_W-1:0]    addr;
        logic [SLICE_W-1:0] data;
    } slice_wr_t;

endpackage

[rtl/round_robin_run_queue_unit.sv]
// round_robin_run_queue_unit: top level of the round-robin run queue
// depends on rrq_pkg, rrq_ram and rrq_core
//
//  channel  | ports                         | direction | word
//  ---------+-------------------------------+-----------+------------------------
//  input    | s_valid s_ready s_data        | in        | opcode, task_id
//  result   | m_valid m_ready m_data        | out       | status .. slice_left
//  config   | cfg_we cfg_wdata              | in        | max_slice, no wait
//
// one word per cycle if m_ready is high; a result is registered as its word retires
// memories are read as a word is taken and written as it retires, with write bypass
// synchronous active-low reset empties the queue and sets max_slice to 5
// no clearing pass after reset; slice entries carry valid bits
// s_ready drops while the input register holds a word and the result register holds
// one that is not being taken
module round_robin_run_queue_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [rrq_pkg::SLICE_W-1:0] cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  rrq_pkg::in_word_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output rrq_pkg::out_word_t          m_data
);

    logic [rrq_pkg::SLICE_W-1:0] max_slice_reg;
    logic                        a_vld_reg;
    rrq_pkg::in_word_t           a_item_reg;
    logic                        m_valid_reg;
    rrq_pkg::out_word_t          m_data_reg;

    logic                        s_accept, fire;
    logic [rrq_pkg::ID_W-1:0]    head_next, slice_raddr;
    logic [rrq_pkg::ID_W-1:0]    next_rd, prev_rd;
    logic [rrq_pkg::SLICE_W-1:0] slice_raw;
    rrq_pkg::out_word_t          result;
    rrq_pkg::link_wr_t           next_wr, prev_wr;
    rrq_pkg::slice_wr_t          slice_wr;

    // word in the input register retires when the result register is free
    assign fire     = a_vld_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !a_vld_reg || fire;
    assign s_accept = s_valid && s_ready;

    // pick reads the slice of the head as it stands after the retiring word
    assign slice_raddr = (s_data.opcode == rrq_pkg::OP_PICK) ? head_next : s_data.task_id;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_slice_reg <= rrq_pkg::MAX_SLICE_RST;
        end else if (cfg_we) begin
            max_slice_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (s_accept) begin
            a_vld_reg <= 1'b1;
        end else if (fire) begin
            a_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_item_reg <= s_data;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // next links by task id
    rrq_ram #(
        .WIDTH (rrq_pkg::ID_W),
        .DEPTH (rrq_pkg::NUM_TASKS)
    ) u_next_ram (
        .aclk  (aclk),
        .we    (next_wr.we),
        .waddr (next_wr.addr),
        .wdata (next_wr.data),
        .re    (s_accept),
        .raddr (s_data.task_id),
        .rdata (next_rd)
    );

    // prev links by task id
    rrq_ram #(
        .WIDTH (rrq_pkg::ID_W),
        .DEPTH (rrq_pkg::NUM_TASKS)
    ) u_prev_ram (
        .aclk  (aclk),
        .we    (prev_wr.we),
        .waddr (prev_wr.addr),
        .wdata (prev_wr.data),
        .re    (s_accept),
        .raddr (s_data.task_id),
        .rdata (prev_rd)
    );

    // remaining slice by task id
    rrq_ram #(
        .WIDTH (rrq_pkg::SLICE_W),
        .DEPTH (rrq_pkg::NUM_TASKS)
    ) u_slice_ram (
        .aclk  (aclk),
        .we    (slice_wr.we),
        .waddr (slice_wr.addr),
        .wdata (slice_wr.data),
        .re    (s_accept),
        .raddr (slice_raddr),
        .rdata (slice_raw)
    );

    rrq_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (a_item_reg),
        .max_slice (max_slice_reg),
        .next_rd   (next_rd),
        .prev_rd   (prev_rd),
        .slice_raw (slice_raw),
        .result    (result),
        .head_next (head_next),
        .next_wr   (next_wr),
        .prev_wr   (prev_wr),
        .slice_wr  (slice_wr)
    );

endmodule

[rtl/rrq_ram.sv]
// rrq_ram: one-write one-read memory with registered read data and write bypass
// no package dependencies
module rrq_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // a read in the same cycle as a write to that entry sees the new data
    always_ff @(posedge aclk) begin
        if (re) begin
            if (we && (waddr == raddr)) begin
                rdata_reg <= wdata;
            end else begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/rrq_core.sv]
// rrq_core: queue control state and the single-pass operation logic
// depends on rrq_pkg; link and slice storage lives in rrq_ram instances above it
module rrq_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         fire,
    input  rrq_pkg::in_word_t            item,
    input  logic [rrq_pkg::SLICE_W-1:0]  max_slice,
    input  logic [rrq_pkg::ID_W-1:0]     next_rd,
    input  logic [rrq_pkg::ID_W-1:0]     prev_rd,
    input  logic [rrq_pkg::SLICE_W-1:0]  slice_raw,
    output rrq_pkg::out_word_t           result,
    output logic [rrq_pkg::ID_W-1:0]     head_next,
    output rrq_pkg::link_wr_t            next_wr,
    output rrq_pkg::link_wr_t            prev_wr,
    output rrq_pkg::slice_wr_t           slice_wr
);

    localparam logic [rrq_pkg::SLICE_W-1:0] SLICE_ONE = rrq_pkg::SLICE_W'(1);
    localparam logic [rrq_pkg::CNT_W-1:0]   CNT_ONE   = rrq_pkg::CNT_W'(1);

    logic [rrq_pkg::ID_W-1:0]      head_reg, tail_reg, head_c, tail_next;
    logic [rrq_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [rrq_pkg::NUM_TASKS-1:0] queued_reg, queued_next;
    logic [rrq_pkg::NUM_TASKS-1:0] valid_reg, valid_next;

    logic [rrq_pkg::ID_W-1:0]    id, slice_addr;
    logic [rrq_pkg::SLICE_W-1:0] slice_rd, new_slice, tick_slice;
    logic                        is_queued, is_head, is_tail;
    rrq_pkg::link_wr_t           next_c, prev_c;
    rrq_pkg::slice_wr_t          slice_c;

    assign id         = item.task_id;
    assign slice_addr = (item.opcode == rrq_pkg::OP_PICK) ? head_reg : id;
    // slice entries never written read as zero
    assign slice_rd   = valid_reg[slice_addr] ? slice_raw : '0;
    assign is_queued  = queued_reg[id];
    assign is_head    = (id == head_reg);
    assign is_tail    = (id == tail_reg);
    assign new_slice  = ((slice_rd == '0) || (slice_rd > max_slice)) ? max_slice : slice_rd;
    assign tick_slice = (slice_rd != '0) ? slice_rd - SLICE_ONE : '0;

    always_comb begin
        head_c      = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        queued_next = queued_reg;
        valid_next  = valid_reg;
        next_c      = '{we: 1'b0, addr: id, data: '0};
        prev_c      = '{we: 1'b0, addr: id, data: '0};
        slice_c     = '{we: 1'b0, addr: id, data: '0};
        result.status       = rrq_pkg::ST_OK;
        result.head_id      = '0;
        result.resched_req  = 1'b0;
        result.slice_left   = slice_rd;
        unique case (item.opcode)
            rrq_pkg::OP_ENQ: begin
                if (is_queued) begin
                    result.status = rrq_pkg::ST_ALREADY;
                end else begin
                    if (count_reg == '0) begin
                        head_c = id;
                    end else begin
                        next_c = '{we: 1'b1, addr: tail_reg, data: id};
                        prev_c = '{we: 1'b1, addr: id, data: tail_reg};
                    end
                    tail_next       = id;
                    queued_next[id] = 1'b1;
                    valid_next[id]  = 1'b1;
                    slice_c         = '{we: 1'b1, addr: id, data: new_slice};
                    count_next      = count_reg + CNT_ONE;
                    result.slice_left = new_slice;
                end
            end
            rrq_pkg::OP_DEQ: begin
                if (!is_queued) begin
                    result.status = rrq_pkg::ST_NOT_QUEUED;
                end else begin
                    if (is_head && is_tail) begin
                        head_c    = '0;
                        tail_next = '0;
                    end else if (is_head) begin
                        head_c = next_rd;
                    end else if (is_tail) begin
                        tail_next = prev_rd;
                    end
                    // middle entry: splice neighbors together
                    if (!is_head && !is_tail) begin
                        next_c = '{we: 1'b1, addr: prev_rd, data: next_rd};
                        prev_c = '{we: 1'b1, addr: next_rd, data: prev_rd};
                    end
                    queued_next[id] = 1'b0;
                    if (count_reg != '0) begin
                        count_next = count_reg - CNT_ONE;
                    end
                end
            end
            rrq_pkg::OP_PICK: begin
                if (count_reg == '0) begin
                    result.status     = rrq_pkg::ST_EMPTY;
                    result.slice_left = '0;
                end else begin
                    result.head_id = head_reg;
                end
            end
            rrq_pkg::OP_TICK: begin
                slice_c             = '{we: 1'b1, addr: id, data: tick_slice};
                valid_next[id]      = 1'b1;
                result.resched_req  = (tick_slice == '0);
                result.slice_left   = tick_slice;
            end
            default: begin
            end
        endcase
        result.queue_count = count_next;
    end

    assign head_next = fire ? head_c : head_reg;
    assign next_wr   = '{we: next_c.we & fire, addr: next_c.addr, data: next_c.data};
    assign prev_wr   = '{we: prev_c.we & fire, addr: prev_c.addr, data: prev_c.data};
    assign slice_wr  = '{we: slice_c.we & fire, addr: slice_c.addr, data: slice_c.data};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            queued_reg <= '0;
            valid_reg  <= '0;
        end else if (fire) begin
            head_reg   <= head_c;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            queued_reg <= queued_next;
            valid_reg  <= valid_next;
        end
    end

    a_count_matches_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(queued_reg) == int'(count_reg))
        else $error("queue count differs from number of queued flags");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(count_reg) <= rrq_pkg::NUM_TASKS)
        else $error("queue count above task count");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> ((head_reg == '0) && (tail_reg == '0)))
        else $error("empty queue with nonzero head or tail");

endmodule
